@@ rtl/ssq_pkg.sv @@
// Shared types and constants for the searchable shift queue.
// No dependencies; every other file in this project imports this package.
`timescale 1ns / 1ps

package ssq_pkg;

  // Request codes carried in s_axis_tuser
  localparam logic [2:0] OP_ENQ    = 3'd0;
  localparam logic [2:0] OP_DEQ    = 3'd1;
  localparam logic [2:0] OP_PEEK   = 3'd2;
  localparam logic [2:0] OP_SEARCH = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam int unsigned OP_W     = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned CAP_W    = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned POS_W    = 4;
  localparam int unsigned COUNT_W  = 5;

  // Result tdata layout, lowest bit first
  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_DATA_LSB   = 2;
  localparam int unsigned OUT_POS_LSB    = 34;
  localparam int unsigned OUT_COUNT_LSB  = 38;
  localparam int unsigned OUT_EMPTY_BIT  = 43;
  localparam int unsigned OUT_FULL_BIT   = 44;
  localparam int unsigned OUT_TDATA_W    = 48;

  // Controller to datapath
  typedef struct packed {
    logic load_in;     // capture request payload
    logic exec;        // execute a request other than a search of a non-empty queue, load result
    logic srch_start;  // clear search step / match state
    logic srch_step;   // compare head, rotate array, advance step
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic srch_run;    // buffered request is a search on a non-empty queue
    logic last_step;   // search step is at the last held entry
  } sts_t;

endpackage

@@ rtl/ssq_ctrl.sv @@
// Controller for the searchable shift queue: request buffer and result
// handshakes, search sequencing. Depends on ssq_pkg.
`timescale 1ns / 1ps

module ssq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_valid_i,
  output logic          s_ready_o,
  output logic          m_valid_o,
  input  logic          m_ready_i,
  input  ssq_pkg::sts_t sts_i,
  output ssq_pkg::cmd_t cmd_o
);
  import ssq_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_SEARCH
  } state_e;

  state_e state_q, state_d;
  logic   in_full_q, in_full_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free, pop, done, accept;

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    pop       = 1'b0;
    done      = 1'b0;
    out_free  = !out_valid_q || m_ready_i;
    unique case (state_q)
      S_IDLE: begin
        if (in_full_q && out_free) begin
          if (sts_i.srch_run) begin
            cmd_o.srch_start = 1'b1;
            state_d          = S_SEARCH;
          end else begin
            cmd_o.exec = 1'b1;
            pop        = 1'b1;
            done       = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        cmd_o.srch_step = 1'b1;
        if (sts_i.last_step) begin
          pop     = 1'b1;
          done    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    s_ready_o     = !in_full_q || pop;
    accept        = s_valid_i && s_ready_o;
    cmd_o.load_in = accept;
    in_full_d     = accept ? 1'b1 : (pop ? 1'b0 : in_full_q);
    out_valid_d   = done ? 1'b1 : (m_ready_i ? 1'b0 : out_valid_q);
  end

  assign m_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      in_full_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      in_full_q   <= in_full_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ rtl/ssq_datapath.sv @@
// Datapath for the searchable shift queue: entry array, occupancy,
// capacity register, search state and result register. Depends on ssq_pkg.
`timescale 1ns / 1ps

module ssq_datapath #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  ssq_pkg::cmd_t                  cmd_i,
  output ssq_pkg::sts_t                  sts_o,
  input  logic                           cfg_we_i,
  input  logic [ssq_pkg::CAP_W-1:0]      cfg_data_i,
  input  logic [ssq_pkg::OP_W-1:0]       in_op_i,
  input  logic [ssq_pkg::VALUE_W-1:0]    in_value_i,
  output logic [ssq_pkg::OUT_TDATA_W-1:0] out_data_o
);
  import ssq_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned IW = $clog2(DEPTH);

  logic [VALUE_W-1:0] entries_q [DEPTH];
  logic [CW-1:0]      occ_q;
  logic [CAP_W-1:0]   cap_q;
  logic [OP_W-1:0]    op_q;
  logic [VALUE_W-1:0] key_q;
  logic [IW-1:0]      step_q;
  logic               found_q, found_d;
  logic [IW-1:0]      pos_q, pos_d;
  logic               hit;

  logic [31:0]        cap_eff, occ_n32, pos32;
  logic [CW-1:0]      occ_n;
  logic               rot_en, enq_wr;
  logic [STATUS_W-1:0] res_status;
  logic [VALUE_W-1:0] res_data;
  logic [IW-1:0]      res_pos;

  logic [STATUS_W-1:0] o_status_q;
  logic [VALUE_W-1:0]  o_data_q;
  logic [POS_W-1:0]    o_pos_q;
  logic [COUNT_W-1:0]  o_count_q;
  logic                o_empty_q, o_full_q;
  logic                load_out;

  assign cap_eff = (32'(cap_q) < DEPTH) ? 32'(cap_q) : 32'(DEPTH);

  assign sts_o.srch_run  = (op_q == OP_SEARCH) && (occ_q != '0);
  assign sts_o.last_step = (CW'(step_q) == occ_q - CW'(1));

  // Search compare at the head; first match wins
  assign hit     = (entries_q[0] == key_q) && !found_q;
  assign found_d = found_q || hit;
  assign pos_d   = hit ? step_q : pos_q;

  always_comb begin
    occ_n      = occ_q;
    rot_en     = 1'b0;
    enq_wr     = 1'b0;
    res_status = ST_OK;
    res_data   = '0;
    res_pos    = '0;
    if (cmd_i.srch_step) begin
      rot_en     = 1'b1;
      res_status = found_d ? ST_OK : ST_NOTFOUND;
      res_pos    = found_d ? pos_d : '0;
    end else begin
      unique case (op_q)
        OP_ENQ: begin
          if (32'(occ_q) >= cap_eff) begin
            res_status = ST_FULL;
          end else begin
            enq_wr = cmd_i.exec;
            occ_n  = occ_q + CW'(1);
          end
        end
        OP_DEQ: begin
          if (occ_q == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_data = entries_q[0];
            rot_en   = cmd_i.exec;
            occ_n    = occ_q - CW'(1);
          end
        end
        OP_PEEK: begin
          if (occ_q == '0) begin
            res_status = ST_EMPTY;
          end else begin
            res_data = entries_q[0];
          end
        end
        OP_SEARCH: res_status = ST_NOTFOUND;  // only reached on an empty queue
        OP_CLEAR:  occ_n = '0;
        default:   occ_n = occ_q;
      endcase
    end
  end

  assign occ_n32  = 32'(occ_n);
  assign pos32    = 32'(res_pos);
  assign load_out = cmd_i.exec || (cmd_i.srch_step && sts_o.last_step);

  // Entry array: rotate within the held entries (dequeue or search), or tail write
  for (genvar i = 0; i < DEPTH; i++) begin : g_entry
    localparam logic [CW-1:0] IDX = CW'(i);
    localparam int unsigned   NXT = (i + 1) % DEPTH;
    always_ff @(posedge clk_i) begin
      if (rot_en && (IDX < occ_q)) begin
        entries_q[i] <= (IDX == occ_q - CW'(1)) ? entries_q[0] : entries_q[NXT];
      end else if (enq_wr && (IDX == occ_q)) begin
        entries_q[i] <= key_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      cap_q <= CAP_W'(16);
    end else begin
      if (cmd_i.exec) begin
        occ_q <= occ_n;
      end
      if (cfg_we_i) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_op_i;
      key_q <= in_value_i;
    end
    if (cmd_i.srch_start) begin
      step_q  <= '0;
      found_q <= 1'b0;
      pos_q   <= '0;
    end else if (cmd_i.srch_step) begin
      step_q  <= step_q + IW'(1);
      found_q <= found_d;
      pos_q   <= pos_d;
    end
    if (load_out) begin
      o_status_q <= res_status;
      o_data_q   <= res_data;
      o_pos_q    <= pos32[POS_W-1:0];
      o_count_q  <= occ_n32[COUNT_W-1:0];
      o_empty_q  <= (occ_n == '0);
      o_full_q   <= (occ_n32 >= cap_eff);
    end
  end

  assign out_data_o = {3'b000, o_full_q, o_empty_q, o_count_q, o_pos_q, o_data_q, o_status_q};

endmodule

@@ rtl/searchable_shift_queue_unit.sv @@
// Top level of the searchable shift queue: stream ports and configuration
// write channel around ssq_ctrl and ssq_datapath. Depends on ssq_pkg.
`timescale 1ns / 1ps

// First-in first-out queue of signed 32-bit values held in a shift register
// array of DEPTH entries. Each request on the slave stream is enqueue,
// dequeue, peek, search or clear (code in s_axis_tuser) and yields exactly
// one result transaction with status, head data, match position, count and
// empty/full flags after the request. A request is buffered one stage, then
// executed. Enqueue, dequeue, peek, clear, unused codes and a search of an
// empty queue are executed directly, so these run back to back at one
// transaction per cycle while the result side is not stalled. A search of a
// non-empty queue first clears the search state, then the array is rotated
// one place per cycle through the held entries while the head is compared
// with the key, leaving the queue in its original order at the end; no new
// request is executed meanwhile. The result register lets the next request
// be taken while a result waits. Capacity (reset 16, effective value
// min(capacity, DEPTH)) may be written on the cfg channel only while the
// block is idle.
module searchable_shift_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // request stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] value
  input  logic [2:0]  s_axis_tuser,   // [2:0] operation
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [1:0] status, [33:2] data, [37:34] position, [42:38] count,
  // [43] empty_res, [44] full_res, [47:45] zero
  output logic [47:0] m_axis_tdata,
  // capacity write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i      // [4:0] capacity
);
  import ssq_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Capacity writes are always taken.
  assign cfg_ready_o = 1'b1;

  ssq_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ssq_datapath #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .in_op_i    (s_axis_tuser),
    .in_value_i (s_axis_tdata),
    .out_data_o (m_axis_tdata)
  );

endmodule

@@ rtl/ssq_checker.sv @@
// Port-level checks for searchable_shift_queue_unit, bound to the top level.
// Depends on ssq_pkg.
`timescale 1ns / 1ps

module ssq_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  import ssq_pkg::*;

  logic [1:0]  status;
  logic [31:0] data;
  logic [3:0]  position;
  logic [4:0]  count;
  logic        empty_f, full_f;

  assign status   = m_axis_tdata[OUT_STATUS_LSB +: 2];
  assign data     = m_axis_tdata[OUT_DATA_LSB +: 32];
  assign position = m_axis_tdata[OUT_POS_LSB +: 4];
  assign count    = m_axis_tdata[OUT_COUNT_LSB +: 5];
  assign empty_f  = m_axis_tdata[OUT_EMPTY_BIT];
  assign full_f   = m_axis_tdata[OUT_FULL_BIT];

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_pos_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (position != 4'd0) |-> status == ST_OK)
    else $error("nonzero position without a successful search");

  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_EMPTY) |-> empty_f && (count == 5'd0) && (data == 32'd0))
    else $error("empty status with held entries or data");

  // A zero capacity answers full on an empty queue, so only the full flag is implied
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_FULL) |-> full_f)
    else $error("full status without full flag");

  a_nf_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (status == ST_NOTFOUND) |-> (data == 32'd0) && (position == 4'd0))
    else $error("failed search with data or position");

endmodule

bind searchable_shift_queue_unit ssq_checker u_ssq_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

@@ tb/searchable_shift_queue_unit_tb.sv @@
// Self-checking testbench for searchable_shift_queue_unit: random request
// streams with stalls on both sides and capacity changes between phases.
// Depends on ssq_pkg and the searchable_shift_queue_unit RTL.
`timescale 1ns / 1ps

module searchable_shift_queue_unit_tb;
  import ssq_pkg::*;

  localparam int unsigned QUEUE_DEPTH = 16;

  // Codes the block treats as no-ops
  localparam logic [2:0] OP_SPARE_A = 3'd5;
  localparam logic [2:0] OP_SPARE_B = 3'd6;
  localparam logic [2:0] OP_SPARE_C = 3'd7;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [VALUE_W-1:0] value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data;
    logic [POS_W-1:0]    position;
    logic [COUNT_W-1:0]  count;
    logic                empty_res;
    logic                full_res;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;   // [31:0] value
  logic [2:0]  s_axis_tuser = '0;   // [2:0] operation
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // [1:0] status, [33:2] data, [37:34] position, [42:38] count,
  // [43] empty_res, [44] full_res, [47:45] zero
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;     // [4:0] capacity

  request_t       pending_reqs[$];      // requests not yet offered
  outcome_t       expected_outcomes[$]; // predicted results, oldest first
  logic [31:0]    held_vals[$];         // shadow of queue contents, head first
  logic [31:0]    recent_vals[$];       // recently enqueued, feeds search keys
  logic [4:0]     capacity_set = 5'd16;
  bit             calm_phase = 1'b0;
  bit             req_taken = 1'b0;
  int             gap_left = 0;
  int             stall_left = 0;
  int             fail_count = 0;

  searchable_shift_queue_unit #(
    .DEPTH(QUEUE_DEPTH)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // Queue behavior: applies one request to the shadow and returns its result
  function automatic outcome_t predict_outcome(request_t req);
    outcome_t res;
    int       eff_cap;
    int       idx;
    res = '0;
    res.status = ST_OK;
    eff_cap = (capacity_set < QUEUE_DEPTH) ? int'(capacity_set) : QUEUE_DEPTH;
    case (req.op)
      OP_ENQ: begin
        if (held_vals.size() >= eff_cap) res.status = ST_FULL;
        else held_vals.push_back(req.value);
      end
      OP_DEQ: begin
        if (held_vals.size() == 0) res.status = ST_EMPTY;
        else res.data = held_vals.pop_front();
      end
      OP_PEEK: begin
        if (held_vals.size() == 0) res.status = ST_EMPTY;
        else res.data = held_vals[0];
      end
      OP_SEARCH: begin
        res.status = ST_NOTFOUND;
        for (idx = 0; idx < held_vals.size(); idx++) begin
          if (res.status == ST_NOTFOUND && held_vals[idx] == req.value) begin
            res.status = ST_OK;
            res.position = 4'(idx);
          end
        end
      end
      OP_CLEAR: held_vals.delete();
      default: ;
    endcase
    res.count = 5'(held_vals.size());
    res.empty_res = (held_vals.size() == 0);
    res.full_res = (held_vals.size() >= eff_cap);
    return res;
  endfunction

  // Idle length: mostly none or short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Extremes, a small pool that forces duplicates, or anything
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      3, 4: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  task automatic queue_req(input logic [2:0] op, input logic [31:0] value);
    pending_reqs.push_back('{op: op, value: value});
  endtask

  // Idle = nothing left to offer, nothing on the bus, nothing outstanding
  task automatic wait_drained();
    do @(posedge clk_i);
    while (pending_reqs.size() != 0 || s_axis_tvalid || expected_outcomes.size() != 0);
  endtask

  task automatic write_capacity(input logic [4:0] cap);
    @(negedge clk_i);
    cfg_data_i <= cap;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    capacity_set = cap;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [4:0] cap, input int n, input int enq_pct,
                           input bit calm);
    logic [31:0] v;
    int          s;
    wait_drained();
    calm_phase = calm;
    write_capacity(cap);
    repeat (n) begin
      if ($urandom_range(0, 99) < enq_pct) begin
        v = pick_value();
        recent_vals.push_back(v);
        if (recent_vals.size() > 24) void'(recent_vals.pop_front());
        queue_req(OP_ENQ, v);
      end else begin
        s = $urandom_range(0, 99);
        if (s < 38) queue_req(OP_DEQ, $urandom);
        else if (s < 53) queue_req(OP_PEEK, $urandom);
        else if (s < 90) begin
          // mostly keys that are likely held, so hits land at all depths
          if (recent_vals.size() != 0 && $urandom_range(0, 99) < 65)
            v = recent_vals[$urandom_range(0, recent_vals.size() - 1)];
          else
            v = pick_value();
          queue_req(OP_SEARCH, v);
        end else if (s < 93) queue_req(OP_CLEAR, $urandom);
        else queue_req(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), $urandom);
      end
    end
  endtask

  // Request driver: holds each transaction until accepted, then may idle for a random gap
  always @(negedge clk_i) begin
    request_t item;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || req_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        item = pending_reqs.pop_front();
        s_axis_tuser <= item.op;
        s_axis_tdata <= item.value;
        s_axis_tvalid <= 1'b1;
        gap_left = calm_phase ? 0 : gap_len();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Result-side backpressure
  always @(negedge clk_i) begin
    if (stall_left == 0 && !calm_phase && $urandom_range(0, 99) < 25)
      stall_left = gap_len();
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Monitor: check result transactions, then predict newly accepted requests
  always @(posedge clk_i) begin
    outcome_t got;
    outcome_t want;
    request_t req;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status    = m_axis_tdata[OUT_STATUS_LSB +: STATUS_W];
        got.data      = m_axis_tdata[OUT_DATA_LSB +: VALUE_W];
        got.position  = m_axis_tdata[OUT_POS_LSB +: POS_W];
        got.count     = m_axis_tdata[OUT_COUNT_LSB +: COUNT_W];
        got.empty_res = m_axis_tdata[OUT_EMPTY_BIT];
        got.full_res  = m_axis_tdata[OUT_FULL_BIT];
        if (expected_outcomes.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, actual %h", $time,
                   m_axis_tdata);
          fail_count++;
        end else begin
          want = expected_outcomes.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("data", want.data, got.data);
          check_field("position", 32'(want.position), 32'(got.position));
          check_field("count", 32'(want.count), 32'(got.count));
          check_field("empty_res", 32'(want.empty_res), 32'(got.empty_res));
          check_field("full_res", 32'(want.full_res), 32'(got.full_res));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        req.op = s_axis_tuser;
        req.value = s_axis_tdata;
        expected_outcomes.push_back(predict_outcome(req));
      end
    end
    req_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty-queue cases, extremes, first-match search, no-op codes
    calm_phase = 1'b1;
    write_capacity(5'd16);
    queue_req(OP_PEEK, 32'h0);
    queue_req(OP_DEQ, 32'h0);
    queue_req(OP_SEARCH, 32'h0);
    queue_req(OP_ENQ, 32'h8000_0000);
    queue_req(OP_ENQ, 32'h7FFF_FFFF);
    queue_req(OP_ENQ, 32'h0000_0000);
    queue_req(OP_ENQ, 32'hFFFF_FFFF);
    queue_req(OP_ENQ, 32'h7FFF_FFFF);
    queue_req(OP_PEEK, 32'hFFFF_FFFF);
    queue_req(OP_SEARCH, 32'h7FFF_FFFF);
    queue_req(OP_SEARCH, 32'hFFFF_FFFF);
    queue_req(OP_SEARCH, 32'h8000_0000);
    queue_req(OP_SEARCH, 32'h0000_3039);
    queue_req(OP_SPARE_A, 32'hFFFF_FFFF);
    queue_req(OP_SPARE_B, 32'h8000_0000);
    queue_req(OP_SPARE_C, 32'h7FFF_FFFF);
    queue_req(OP_DEQ, 32'h0);
    queue_req(OP_CLEAR, 32'h0);
    queue_req(OP_DEQ, 32'h0);

    // Fill to the built depth so the next phase starts above its capacity
    run_phase(5'd16, 110, 60, 1'b0);
    repeat (16) queue_req(OP_ENQ, $urandom);
    run_phase(5'd3, 80, 40, 1'b0);
    run_phase(5'd1, 90, 50, 1'b0);
    run_phase(5'd0, 50, 50, 1'b0);
    run_phase(5'd31, 110, 65, 1'b1);
    run_phase(5'd17, 100, 55, 1'b0);
    run_phase(5'($urandom_range(1, 16)), 100, 50, 1'b0);
    run_phase(5'($urandom_range(0, 31)), 100, 60, 1'b0);
    run_phase(5'd16, 100, 55, 1'b0);

    wait_drained();
    repeat (24) @(posedge clk_i);
    if (fail_count == 0 && expected_outcomes.size() == 0) begin
      $display("** searchable_shift_queue_unit: PASSED **");
    end else begin
      $display("** searchable_shift_queue_unit: FAILED **");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("** searchable_shift_queue_unit: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
rtl/ssq_pkg.sv
rtl/ssq_ctrl.sv
rtl/ssq_datapath.sv
rtl/searchable_shift_queue_unit.sv
rtl/ssq_checker.sv
tb/searchable_shift_queue_unit_tb.sv
